@@ hw/rtl/bsck_pkg.sv @@
// Shared types, constants and bit permutation functions for the board symmetry key block.
// No dependencies; every other file in this folder except bsck_req_if uses it by scoped names.

package bsck_pkg;

   typedef logic [2:0] xform_type;

   localparam xform_type XF_IDENTITY   = 3'd0;
   localparam xform_type XF_ROT_CW     = 3'd1;
   localparam xform_type XF_ROT_180    = 3'd2;
   localparam xform_type XF_ROT_CCW    = 3'd3;
   localparam xform_type XF_MIRROR_COL = 3'd4;
   localparam xform_type XF_ANTI_DIAG  = 3'd5;
   localparam xform_type XF_MIRROR_ROW = 3'd6;
   localparam xform_type XF_DIAG       = 3'd7;

   localparam int NUM_XFORMS = 8;

   localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;
   localparam logic [63:0] SALT_FIRST  = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] SALT_SECOND = 64'h243f6a8885a308d3;

   typedef struct packed {
      logic [63:0] black;
      logic [63:0] white;
      xform_type   tid;
      logic        side;
   } cand_type;

   typedef struct packed {
      logic [63:0] ll;
      logic [31:0] hl;
      logic [31:0] lh;
   } prod_type;

   typedef struct packed {
      logic [63:0] canon_black;
      logic [63:0] canon_white;
      xform_type   transform_id;
      logic [63:0] key_hash;
   } rsp_type;

   function automatic logic [63:0] sym_permute(input logic [63:0] m, input xform_type t);
      logic [63:0] res;
      logic [2:0]  r;
      logic [2:0]  c;
      logic [2:0]  nr;
      logic [2:0]  nc;
      res = '0;
      for (int sq = 0; sq < 64; sq++) begin
         r = 3'(sq >> 3);
         c = 3'(sq);
         case (t)
            XF_IDENTITY:   begin nr = r;         nc = c;         end
            XF_ROT_CW:     begin nr = c;         nc = 3'd7 - r;  end
            XF_ROT_180:    begin nr = 3'd7 - r;  nc = 3'd7 - c;  end
            XF_ROT_CCW:    begin nr = 3'd7 - c;  nc = r;         end
            XF_MIRROR_COL: begin nr = r;         nc = 3'd7 - c;  end
            XF_ANTI_DIAG:  begin nr = 3'd7 - c;  nc = 3'd7 - r;  end
            XF_MIRROR_ROW: begin nr = 3'd7 - r;  nc = c;         end
            XF_DIAG:       begin nr = c;         nc = r;         end
            default:       begin nr = r;         nc = c;         end
         endcase
         res[{nr, nc}] = m[sq];
      end
      return res;
   endfunction

   function automatic logic cand_less(input cand_type a, input cand_type b);
      return {a.black, a.white} < {b.black, b.white};
   endfunction

endpackage

@@ hw/rtl/bsck_req_if.sv @@
// Request channel interface: valid, ready and one board position per beat.
// Depends on nothing.

interface bsck_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] black_bits;
   logic [63:0] white_bits;
   logic        side_to_move;

   modport source (output valid, output black_bits, output white_bits, output side_to_move,
                   input ready);
   modport sink (input valid, input black_bits, input white_bits, input side_to_move,
                 output ready);
endinterface

@@ hw/rtl/bsck_rsp_if.sv @@
// Response channel interface: valid, ready and one canonical key per beat.
// Uses bsck_pkg for the transform code type.

interface bsck_rsp_if;
   logic                valid;
   logic                ready;
   logic [63:0]         canon_black;
   logic [63:0]         canon_white;
   bsck_pkg::xform_type transform_id;
   logic [63:0]         key_hash;

   modport source (output valid, output canon_black, output canon_white,
                   output transform_id, output key_hash, input ready);
   modport sink (input valid, input canon_black, input canon_white,
                 input transform_id, input key_hash, output ready);
endinterface

@@ hw/rtl/board_symmetry_canonical_key.sv @@
// Top level of the board symmetry canonical key block: symmetry selection then hashing.
// Uses bsck_pkg, bsck_req_if, bsck_rsp_if, bsck_sym_select and bsck_mix.
//
//   channel   | dir | beat contents
//   ----------+-----+-------------------------------------------------------
//   req_chan  | in  | black_bits, white_bits, side_to_move
//   rsp_chan  | out | canon_black, canon_white, transform_id, key_hash
//
// One beat is accepted per cycle while rsp_chan.ready does not hold the pipeline.
// The depth is set by the three-level comparison tree and the two split multiplies.
// Reset clears only the stage valid bits; payload registers hold stale data.
// Each stage holds while the stage after it is full and held, so rsp_chan.ready
// back-pressures req_chan.ready combinationally through all seven stages.

module board_symmetry_canonical_key (
   input logic        clock,
   input logic        reset,
   bsck_req_if.sink   req_chan,
   bsck_rsp_if.source rsp_chan
);

   logic               sel_valid;
   logic               sel_ready;
   bsck_pkg::cand_type sel_cand;
   bsck_pkg::rsp_type  mix_rsp;

   bsck_sym_select u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_black  (req_chan.black_bits),
      .in_white  (req_chan.white_bits),
      .in_side   (req_chan.side_to_move),
      .out_valid (sel_valid),
      .out_ready (sel_ready),
      .out_cand  (sel_cand)
   );

   bsck_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sel_valid),
      .in_ready  (sel_ready),
      .in_cand   (sel_cand),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_rsp   (mix_rsp)
   );

   assign rsp_chan.canon_black  = mix_rsp.canon_black;
   assign rsp_chan.canon_white  = mix_rsp.canon_white;
   assign rsp_chan.transform_id = mix_rsp.transform_id;
   assign rsp_chan.key_hash     = mix_rsp.key_hash;

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (rsp_chan.valid && !rsp_chan.ready))
      else $error("request side stalled without a held response");

   a_empty_board_identity: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.canon_black == 64'd0 && rsp_chan.canon_white == 64'd0)
      |-> (rsp_chan.transform_id == bsck_pkg::XF_IDENTITY))
      else $error("empty board did not select the identity");

   a_min_under_rotation: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
      ({bsck_pkg::sym_permute(rsp_chan.canon_black, bsck_pkg::XF_ROT_CW),
        bsck_pkg::sym_permute(rsp_chan.canon_white, bsck_pkg::XF_ROT_CW)}
       >= {rsp_chan.canon_black, rsp_chan.canon_white}))
      else $error("canonical pair is not minimal under rotation");

   a_min_under_transpose: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
      ({bsck_pkg::sym_permute(rsp_chan.canon_black, bsck_pkg::XF_DIAG),
        bsck_pkg::sym_permute(rsp_chan.canon_white, bsck_pkg::XF_DIAG)}
       >= {rsp_chan.canon_black, rsp_chan.canon_white}))
      else $error("canonical pair is not minimal under transpose");
`endif

endmodule

@@ hw/rtl/bsck_sym_select.sv @@
// Three-stage symmetry selection: eight permuted candidates reduced by a registered
// comparison tree to the smallest mask pair. Uses bsck_pkg.

module bsck_sym_select (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [63:0]        in_black,
   input  logic [63:0]        in_white,
   input  logic               in_side,
   output logic               out_valid,
   input  logic               out_ready,
   output bsck_pkg::cand_type out_cand
);

   bsck_pkg::cand_type cand_all [bsck_pkg::NUM_XFORMS];

   logic               s1_valid_ff;
   logic               s1_valid_in;
   bsck_pkg::cand_type s1_cand_ff [4];
   bsck_pkg::cand_type s1_cand_in [4];
   logic               s2_valid_ff;
   logic               s2_valid_in;
   bsck_pkg::cand_type s2_cand_ff [2];
   bsck_pkg::cand_type s2_cand_in [2];
   logic               s3_valid_ff;
   logic               s3_valid_in;
   bsck_pkg::cand_type s3_cand_ff;
   bsck_pkg::cand_type s3_cand_in;

   logic s1_ready;
   logic s2_ready;
   logic s3_ready;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // The higher-numbered candidate of a pair wins only when strictly smaller.
   always_comb begin
      for (int t = 0; t < bsck_pkg::NUM_XFORMS; t++) begin
         cand_all[t].black = bsck_pkg::sym_permute(in_black, bsck_pkg::xform_type'(t));
         cand_all[t].white = bsck_pkg::sym_permute(in_white, bsck_pkg::xform_type'(t));
         cand_all[t].tid   = bsck_pkg::xform_type'(t);
         cand_all[t].side  = in_side;
      end
      for (int i = 0; i < 4; i++) begin
         s1_cand_in[i] = bsck_pkg::cand_less(cand_all[2*i+1], cand_all[2*i]) ?
                         cand_all[2*i+1] : cand_all[2*i];
      end
      for (int i = 0; i < 2; i++) begin
         s2_cand_in[i] = bsck_pkg::cand_less(s1_cand_ff[2*i+1], s1_cand_ff[2*i]) ?
                         s1_cand_ff[2*i+1] : s1_cand_ff[2*i];
      end
      s3_cand_in = bsck_pkg::cand_less(s2_cand_ff[1], s2_cand_ff[0]) ?
                   s2_cand_ff[1] : s2_cand_ff[0];
   end

   assign s1_valid_in = in_valid;
   assign s2_valid_in = s1_valid_ff;
   assign s3_valid_in = s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= s1_valid_in;
         if (s2_ready) s2_valid_ff <= s2_valid_in;
         if (s3_ready) s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) s1_cand_ff <= s1_cand_in;
      if (s2_ready) s2_cand_ff <= s2_cand_in;
      if (s3_ready) s3_cand_ff <= s3_cand_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_cand  = s3_cand_ff;

endmodule

@@ hw/rtl/bsck_mix.sv @@
// Four-stage splitmix64 finalizer of both canonical masks and the salted key hash.
// Each 64-bit multiply is split into 32-bit partial products. Uses bsck_pkg.

module bsck_mix (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  bsck_pkg::cand_type in_cand,
   output logic               out_valid,
   input  logic               out_ready,
   output bsck_pkg::rsp_type  out_rsp
);

   function automatic bsck_pkg::prod_type mul_parts(input logic [63:0] u, input logic [63:0] k);
      bsck_pkg::prod_type p;
      p.ll = 64'(u[31:0]) * 64'(k[31:0]);
      p.hl = 32'(u[63:32] * k[31:0]);
      p.lh = 32'(u[31:0] * k[63:32]);
      return p;
   endfunction

   function automatic logic [63:0] mul_sum(input bsck_pkg::prod_type p);
      logic [31:0] cross_sum;
      cross_sum = p.hl + p.lh;
      return p.ll + {cross_sum, 32'd0};
   endfunction

   logic               m1_valid_ff, m1_valid_in;
   bsck_pkg::cand_type m1_cand_ff;
   bsck_pkg::prod_type m1_pb_ff, m1_pb_in, m1_pw_ff, m1_pw_in;

   logic               m2_valid_ff, m2_valid_in;
   bsck_pkg::cand_type m2_cand_ff;
   logic [63:0]        m2_vb_ff, m2_vb_in, m2_vw_ff, m2_vw_in;

   logic               m3_valid_ff, m3_valid_in;
   bsck_pkg::cand_type m3_cand_ff;
   bsck_pkg::prod_type m3_pb_ff, m3_pb_in, m3_pw_ff, m3_pw_in;

   logic               m4_valid_ff, m4_valid_in;
   bsck_pkg::rsp_type  m4_rsp_ff, m4_rsp_in;

   logic [63:0] fin_b;
   logic [63:0] fin_w;
   logic [63:0] salt;

   logic m1_ready, m2_ready, m3_ready, m4_ready;

   assign m4_ready = !m4_valid_ff || out_ready;
   assign m3_ready = !m3_valid_ff || m4_ready;
   assign m2_ready = !m2_valid_ff || m3_ready;
   assign m1_ready = !m1_valid_ff || m2_ready;
   assign in_ready = m1_ready;

   assign m1_valid_in = in_valid;
   assign m2_valid_in = m1_valid_ff;
   assign m3_valid_in = m2_valid_ff;
   assign m4_valid_in = m3_valid_ff;

   always_comb begin
      m1_pb_in = mul_parts(in_cand.black ^ (in_cand.black >> 30), bsck_pkg::MIX_MUL_A);
      m1_pw_in = mul_parts(in_cand.white ^ (in_cand.white >> 30), bsck_pkg::MIX_MUL_A);
      m2_vb_in = mul_sum(m1_pb_ff);
      m2_vw_in = mul_sum(m1_pw_ff);
      m3_pb_in = mul_parts(m2_vb_ff ^ (m2_vb_ff >> 27), bsck_pkg::MIX_MUL_B);
      m3_pw_in = mul_parts(m2_vw_ff ^ (m2_vw_ff >> 27), bsck_pkg::MIX_MUL_B);
      fin_b    = mul_sum(m3_pb_ff);
      fin_w    = mul_sum(m3_pw_ff);
      salt     = m3_cand_ff.side ? bsck_pkg::SALT_SECOND : bsck_pkg::SALT_FIRST;
      m4_rsp_in.canon_black  = m3_cand_ff.black;
      m4_rsp_in.canon_white  = m3_cand_ff.white;
      m4_rsp_in.transform_id = m3_cand_ff.tid;
      m4_rsp_in.key_hash     = (fin_b ^ (fin_b >> 31)) ^ ((fin_w ^ (fin_w >> 31)) << 1) ^ salt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
         m4_valid_ff <= 1'b0;
      end else begin
         if (m1_ready) m1_valid_ff <= m1_valid_in;
         if (m2_ready) m2_valid_ff <= m2_valid_in;
         if (m3_ready) m3_valid_ff <= m3_valid_in;
         if (m4_ready) m4_valid_ff <= m4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (m1_ready) begin
         m1_cand_ff <= in_cand;
         m1_pb_ff   <= m1_pb_in;
         m1_pw_ff   <= m1_pw_in;
      end
      if (m2_ready) begin
         m2_cand_ff <= m1_cand_ff;
         m2_vb_ff   <= m2_vb_in;
         m2_vw_ff   <= m2_vw_in;
      end
      if (m3_ready) begin
         m3_cand_ff <= m2_cand_ff;
         m3_pb_ff   <= m3_pb_in;
         m3_pw_ff   <= m3_pw_in;
      end
      if (m4_ready) begin
         m4_rsp_ff <= m4_rsp_in;
      end
   end

   assign out_valid = m4_valid_ff;
   assign out_rsp   = m4_rsp_ff;

endmodule
